// ----- rtl/core/ptt_pkg.sv -----
// ptt_pkg: shared types and codes for the push-to-talk gesture machine.
// No dependencies; used by every module in rtl/core.
`default_nettype none

package ptt_pkg;

	// event kinds
	localparam logic [1:0] EV_PRESS   = 2'd0;
	localparam logic [1:0] EV_RELEASE = 2'd1;
	localparam logic [1:0] EV_TICK    = 2'd2;
	localparam logic [1:0] EV_CANCEL  = 2'd3;

	// phases
	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_ARMING  = 2'd1;
	localparam logic [1:0] PH_TALKING = 2'd2;

	// actions
	localparam logic [1:0] ACT_NOTHING = 2'd0;
	localparam logic [1:0] ACT_START   = 2'd1;
	localparam logic [1:0] ACT_SEND    = 2'd2;
	localparam logic [1:0] ACT_DISCARD = 2'd3;

	// discard reasons
	localparam logic [1:0] WHY_NONE  = 2'd0;
	localparam logic [1:0] WHY_SHORT = 2'd1;
	localparam logic [1:0] WHY_LONG  = 2'd2;

	// register indexes
	localparam logic [1:0] REG_ARM_TIME   = 2'd0;
	localparam logic [1:0] REG_MIN_SPEECH = 2'd1;
	localparam logic [1:0] REG_MAX_TALK   = 2'd2;

	localparam int unsigned CFG_DATA_W = 24;

	// register reset values
	localparam logic [15:0] ARM_TIME_RST   = 16'd120;
	localparam logic [15:0] MIN_SPEECH_RST = 16'd350;
	localparam logic [23:0] MAX_TALK_RST   = 24'd30000;

	typedef struct packed {
		logic [15:0] arm_time;
		logic [15:0] min_speech_time;
		logic [23:0] max_talk_time;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  phase;
		logic [31:0] press_stamp;
		logic [31:0] talk_stamp;
		logic [1:0]  last_reason;
	} state_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [1:0]  phase_out;
		logic [1:0]  discard_reason;
		logic [31:0] talk_elapsed;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/core/ptt_cfg_regs.sv -----
// ptt_cfg_regs: configuration register file (arm, minimum speech, maximum talk).
// Depends on ptt_pkg.
`default_nettype none

module ptt_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [1:0]                      cfg_index,
	input  wire logic [ptt_pkg::CFG_DATA_W-1:0]  cfg_data,
	output ptt_pkg::cfg_t                        cfg
);

	ptt_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.arm_time        <= ptt_pkg::ARM_TIME_RST;
			cfg_q.min_speech_time <= ptt_pkg::MIN_SPEECH_RST;
			cfg_q.max_talk_time   <= ptt_pkg::MAX_TALK_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ptt_pkg::REG_ARM_TIME:   cfg_q.arm_time        <= cfg_data[15:0];
				ptt_pkg::REG_MIN_SPEECH: cfg_q.min_speech_time <= cfg_data[15:0];
				ptt_pkg::REG_MAX_TALK:   cfg_q.max_talk_time   <= cfg_data[23:0];
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/core/ptt_step.sv -----
// ptt_step: next-state and result logic for one gesture event.
// Depends on ptt_pkg; purely combinational.
`default_nettype none

module ptt_step (
	input  wire ptt_pkg::cfg_t   cfg,
	input  wire ptt_pkg::state_t cur,
	input  wire logic [1:0]      mode,
	input  wire logic [31:0]     now_time,
	output ptt_pkg::state_t      nxt,
	output ptt_pkg::result_t     res
);

	logic [1:0]  phase;
	logic [31:0] since_press;
	logic [31:0] since_talk;
	logic [31:0] talk_run;
	logic [1:0]  act;

	assign since_press = now_time - cur.press_stamp;
	assign since_talk  = now_time - cur.talk_stamp;

	always_comb begin
		// an out-of-range phase behaves as idle
		phase = (cur.phase == ptt_pkg::PH_ARMING || cur.phase == ptt_pkg::PH_TALKING) ?
			cur.phase : ptt_pkg::PH_IDLE;
		nxt       = cur;
		nxt.phase = phase;
		act       = ptt_pkg::ACT_NOTHING;
		case (mode)
			ptt_pkg::EV_PRESS: begin
				if (phase == ptt_pkg::PH_IDLE) begin
					nxt.phase       = ptt_pkg::PH_ARMING;
					nxt.press_stamp = now_time;
					nxt.last_reason = ptt_pkg::WHY_NONE;
					if (cfg.arm_time == 16'd0) begin
						nxt.phase      = ptt_pkg::PH_TALKING;
						nxt.talk_stamp = now_time;
						act            = ptt_pkg::ACT_START;
					end
				end
			end
			ptt_pkg::EV_RELEASE: begin
				if (phase == ptt_pkg::PH_ARMING) begin
					nxt.phase = ptt_pkg::PH_IDLE;
				end else if (phase == ptt_pkg::PH_TALKING) begin
					nxt.phase = ptt_pkg::PH_IDLE;
					if (since_talk < {16'd0, cfg.min_speech_time}) begin
						nxt.last_reason = ptt_pkg::WHY_SHORT;
						act             = ptt_pkg::ACT_DISCARD;
					end else begin
						act = ptt_pkg::ACT_SEND;
					end
				end
			end
			ptt_pkg::EV_TICK: begin
				if (phase == ptt_pkg::PH_ARMING) begin
					if (since_press >= {16'd0, cfg.arm_time}) begin
						nxt.phase      = ptt_pkg::PH_TALKING;
						nxt.talk_stamp = now_time;
						act            = ptt_pkg::ACT_START;
					end
				end else if (phase == ptt_pkg::PH_TALKING) begin
					if (cfg.max_talk_time != 24'd0 &&
					    since_talk >= {8'd0, cfg.max_talk_time}) begin
						nxt.phase       = ptt_pkg::PH_IDLE;
						nxt.last_reason = ptt_pkg::WHY_LONG;
						act             = ptt_pkg::ACT_DISCARD;
					end
				end
			end
			ptt_pkg::EV_CANCEL: begin
				if (phase == ptt_pkg::PH_TALKING) begin
					nxt.last_reason = ptt_pkg::WHY_NONE;
					act             = ptt_pkg::ACT_DISCARD;
				end
				nxt.phase = ptt_pkg::PH_IDLE;
			end
			default: ;
		endcase
	end

	// talk stamp only moves when talking starts, and then elapsed is zero
	assign talk_run = (nxt.phase == ptt_pkg::PH_TALKING && nxt.talk_stamp == cur.talk_stamp) ?
		since_talk : 32'd0;

	always_comb begin
		res.action         = act;
		res.phase_out      = nxt.phase;
		res.discard_reason = nxt.last_reason;
		res.talk_elapsed   = talk_run;
	end

endmodule

`default_nettype wire

// ----- rtl/core/push_to_talk_gesture_fsm_unit.sv -----
// Push-to-talk gesture machine: idle, arming and talking phases driven by events.
// Registers: input register, then result register.
// Throughput: one event per cycle unless the consumer stalls; the gesture state updates
// as an event leaves the input register, so the following event sees it with no gap.
// Reset (arst_n low, asynchronous): pipeline empty, phase idle, stamps zero,
// discard reason none, registers at 120 / 350 / 30000 ms.
`default_nettype none

module push_to_talk_gesture_fsm_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration write port
	input  wire logic                            cfg_we,
	input  wire logic [1:0]                      cfg_index,
	input  wire logic [ptt_pkg::CFG_DATA_W-1:0]  cfg_data,
	// event channel
	input  wire logic                            in_valid,
	output      logic                            in_ready,
	input  wire logic [1:0]                      mode,
	input  wire logic [31:0]                     now_time,
	// result channel
	output      logic                            out_valid,
	input  wire logic                            out_ready,
	output      logic [1:0]                      action,
	output      logic [1:0]                      phase_out,
	output      logic [1:0]                      discard_reason,
	output      logic [31:0]                     talk_elapsed
);

	ptt_pkg::cfg_t    cfg;
	ptt_pkg::state_t  state_q;
	ptt_pkg::state_t  state_nxt;
	ptt_pkg::result_t res_nxt;
	ptt_pkg::result_t res_s2;

	logic        valid_s1;
	logic [1:0]  mode_s1;
	logic [31:0] now_s1;
	logic        valid_s2;
	logic        s2_free;
	logic        adv_s1;

	ptt_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ptt_step u_step (
		.cfg      (cfg),
		.cur      (state_q),
		.mode     (mode_s1),
		.now_time (now_s1),
		.nxt      (state_nxt),
		.res      (res_nxt)
	);

	// Result register empties or drains this cycle: stage 1 may move forward.
	assign s2_free  = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && s2_free;
	// Accept a new transaction whenever stage 1 is empty or moving on.
	assign in_ready = !valid_s1 || s2_free;

	// Input register: capture the event as the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1 <= mode;
			now_s1  <= now_time;
		end
	end

	// Gesture state: commit exactly once per event, as it enters the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase       <= ptt_pkg::PH_IDLE;
			state_q.press_stamp <= 32'd0;
			state_q.talk_stamp  <= 32'd0;
			state_q.last_reason <= ptt_pkg::WHY_NONE;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// Result register: hold while the consumer stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid      = valid_s2;
	assign action         = res_s2.action;
	assign phase_out      = res_s2.phase_out;
	assign discard_reason = res_s2.discard_reason;
	assign talk_elapsed   = res_s2.talk_elapsed;

endmodule

`default_nettype wire

// ----- verif/push_to_talk_gesture_fsm_unit_tb.sv -----
// Self-checking testbench for push_to_talk_gesture_fsm_unit: directed gestures,
// then random press/tick/release/cancel sequences under several timing settings.
// Depends on ptt_pkg (codes, reset values, result_t) and the unit itself.
`timescale 1ns / 100ps

module push_to_talk_gesture_fsm_unit_tb;

	// index past the last register; writes to it must change nothing
	localparam logic [1:0] REG_UNUSED = 2'd3;

	// Scoreboard: keeps its own copy of the gesture state and timing registers,
	// predicts the result of each accepted event and checks results in order.
	class ptt_scoreboard;
		logic [15:0]      arm;
		logic [15:0]      min_speech;
		logic [23:0]      max_talk;
		logic [1:0]       phase;
		logic [31:0]      press_at;
		logic [31:0]      talk_at;
		logic [1:0]       reason;
		ptt_pkg::result_t gesture_results_q[$];
		int               errors;
		int               n_events;
		int               n_results;
		int               n_starts;
		int               n_sends;
		int               n_discards;

		function new();
			arm        = ptt_pkg::ARM_TIME_RST;
			min_speech = ptt_pkg::MIN_SPEECH_RST;
			max_talk   = ptt_pkg::MAX_TALK_RST;
			phase      = ptt_pkg::PH_IDLE;
			press_at   = '0;
			talk_at    = '0;
			reason     = ptt_pkg::WHY_NONE;
			errors     = 0;
			n_events   = 0;
			n_results  = 0;
			n_starts   = 0;
			n_sends    = 0;
			n_discards = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [23:0] val);
			case (idx)
				ptt_pkg::REG_ARM_TIME:   arm        = val[15:0];
				ptt_pkg::REG_MIN_SPEECH: min_speech = val[15:0];
				ptt_pkg::REG_MAX_TALK:   max_talk   = val;
				default: ;
			endcase
		endfunction

		function int pending();
			return gesture_results_q.size();
		endfunction

		// Advance the gesture state by one event and queue the result it yields.
		function void note_event(logic [1:0] ev, logic [31:0] t);
			ptt_pkg::result_t r;
			logic [1:0]       act;
			logic [31:0]      since_talk;
			logic [31:0]      since_press;
			act         = ptt_pkg::ACT_NOTHING;
			since_talk  = t - talk_at;
			since_press = t - press_at;
			if (phase > ptt_pkg::PH_TALKING)
				phase = ptt_pkg::PH_IDLE;
			case (ev)
				ptt_pkg::EV_PRESS: begin
					if (phase == ptt_pkg::PH_IDLE) begin
						phase    = ptt_pkg::PH_ARMING;
						press_at = t;
						reason   = ptt_pkg::WHY_NONE;
						if (arm == 16'd0) begin
							phase   = ptt_pkg::PH_TALKING;
							talk_at = t;
							act     = ptt_pkg::ACT_START;
						end
					end
				end
				ptt_pkg::EV_RELEASE: begin
					if (phase == ptt_pkg::PH_ARMING) begin
						phase = ptt_pkg::PH_IDLE;
					end else if (phase == ptt_pkg::PH_TALKING) begin
						phase = ptt_pkg::PH_IDLE;
						if (since_talk < {16'd0, min_speech}) begin
							reason = ptt_pkg::WHY_SHORT;
							act    = ptt_pkg::ACT_DISCARD;
						end else begin
							act = ptt_pkg::ACT_SEND;
						end
					end
				end
				ptt_pkg::EV_TICK: begin
					if (phase == ptt_pkg::PH_ARMING) begin
						if (since_press >= {16'd0, arm}) begin
							phase   = ptt_pkg::PH_TALKING;
							talk_at = t;
							act     = ptt_pkg::ACT_START;
						end
					end else if (phase == ptt_pkg::PH_TALKING) begin
						if (max_talk != 24'd0 && since_talk >= {8'd0, max_talk}) begin
							phase  = ptt_pkg::PH_IDLE;
							reason = ptt_pkg::WHY_LONG;
							act    = ptt_pkg::ACT_DISCARD;
						end
					end
				end
				default: begin
					if (phase == ptt_pkg::PH_TALKING) begin
						reason = ptt_pkg::WHY_NONE;
						act    = ptt_pkg::ACT_DISCARD;
					end
					phase = ptt_pkg::PH_IDLE;
				end
			endcase
			r.action         = act;
			r.phase_out      = phase;
			r.discard_reason = reason;
			r.talk_elapsed   = (phase == ptt_pkg::PH_TALKING) ? t - talk_at : 32'd0;
			gesture_results_q.push_back(r);
			n_events++;
			if (act == ptt_pkg::ACT_START)   n_starts++;
			if (act == ptt_pkg::ACT_SEND)    n_sends++;
			if (act == ptt_pkg::ACT_DISCARD) n_discards++;
		endfunction

		// Compare one accepted result against the oldest prediction.
		function void check_result(logic [1:0] act, logic [1:0] ph, logic [1:0] why,
				logic [31:0] el);
			ptt_pkg::result_t e;
			if (gesture_results_q.size() == 0) begin
				$display("%0t: result with nothing expected: %s %0d %0d %0d %0d",
					$time, "action phase reason elapsed", act, ph, why, el);
				errors++;
				return;
			end
			e = gesture_results_q.pop_front();
			n_results++;
			if (act !== e.action) begin
				$display("%0t: action mismatch: expected %0d, actual %0d",
					$time, e.action, act);
				errors++;
			end
			if (ph !== e.phase_out) begin
				$display("%0t: phase_out mismatch: expected %0d, actual %0d",
					$time, e.phase_out, ph);
				errors++;
			end
			if (why !== e.discard_reason) begin
				$display("%0t: discard_reason mismatch: expected %0d, actual %0d",
					$time, e.discard_reason, why);
				errors++;
			end
			if (el !== e.talk_elapsed) begin
				$display("%0t: talk_elapsed mismatch: expected %0d, actual %0d",
					$time, e.talk_elapsed, el);
				errors++;
			end
		endfunction
	endclass

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           cfg_we    = 1'b0;
	logic [1:0]                     cfg_index = '0;
	logic [ptt_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
	logic                           in_valid  = 1'b0;
	logic                           in_ready;
	logic [1:0]                     mode      = '0;
	logic [31:0]                    now_time  = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [1:0]                     action;
	logic [1:0]                     phase_out;
	logic [1:0]                     discard_reason;
	logic [31:0]                    talk_elapsed;

	ptt_scoreboard sb = new();
	bit            calm = 1'b0;     // set to suppress idling on both channels
	logic [31:0]   ms_now = 32'd0;  // running timestamp for random gestures
	int            n_settings = 1;

	push_to_talk_gesture_fsm_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.now_time       (now_time),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.action         (action),
		.phase_out      (phase_out),
		.discard_reason (discard_reason),
		.talk_elapsed   (talk_elapsed)
	);

	always #1 clk = ~clk;

	// Stall the result channel about 27 percent of the time unless calm.
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(0, 99) >= 27);
	end

	// Sample the result channel mid-cycle, where handshake and payload are stable;
	// a transaction seen here completes at the next rising edge.
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(action, phase_out, discard_reason, talk_elapsed);
	end

	// Offer one event, idling first at random; return right after the rising
	// edge that accepts it, with valid still high.
	task automatic push_event(input logic [1:0] ev, input logic [31:0] t);
		while (!calm && $urandom_range(0, 99) < 27) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= ev;
		now_time <= t;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		sb.note_event(ev, t);
	endtask

	// Hold the sender until every predicted result has come back, then let the
	// pipeline settle.
	task automatic wait_drain();
		int n;
		n = 0;
		while (sb.pending() > 0 && n < 20000) begin
			@(posedge clk);
			n++;
		end
		if (sb.pending() > 0) begin
			$display("%0t: %0d results never arrived", $time, sb.pending());
			sb.errors++;
		end
		repeat (4) @(posedge clk);
	endtask

	// Reprogram all three timing registers plus the unused index while idle.
	task automatic program_timing(input logic [23:0] a, input logic [23:0] m,
			input logic [23:0] x);
		logic [23:0] junk;
		junk = 24'($urandom);
		in_valid <= 1'b0;
		wait_drain();
		cfg_we    <= 1'b1;
		cfg_index <= ptt_pkg::REG_ARM_TIME;
		cfg_data  <= a;
		@(posedge clk);
		sb.write_reg(ptt_pkg::REG_ARM_TIME, a);
		cfg_index <= ptt_pkg::REG_MIN_SPEECH;
		cfg_data  <= m;
		@(posedge clk);
		sb.write_reg(ptt_pkg::REG_MIN_SPEECH, m);
		cfg_index <= ptt_pkg::REG_MAX_TALK;
		cfg_data  <= x;
		@(posedge clk);
		sb.write_reg(ptt_pkg::REG_MAX_TALK, x);
		cfg_index <= REG_UNUSED;
		cfg_data  <= junk;
		@(posedge clk);
		sb.write_reg(REG_UNUSED, junk);
		cfg_we <= 1'b0;
		@(posedge clk);
		n_settings++;
	endtask

	// Time step between events: aim near the current thresholds often, so the
	// comparisons land on both sides of their boundaries; sometimes jump far.
	function automatic logic [31:0] pick_gap();
		case ($urandom_range(0, 9))
			0:       return 32'd0;
			1:       return 32'd1;
			2, 3, 4: return $urandom_range(0, 400);
			5:       return {16'd0, sb.arm} + $urandom_range(0, 4) - 32'd2;
			6:       return {16'd0, sb.min_speech} + $urandom_range(0, 4) - 32'd2;
			7:       return {8'd0, sb.max_talk} + $urandom_range(0, 4) - 32'd2;
			8:       return $urandom_range(0, 40000);
			default: return $urandom;
		endcase
	endfunction

	// Mostly well-formed gestures (press, ticks, release or cancel) with random
	// timing; the rest is noise with random kind and timestamp.
	task automatic run_gestures(input int n);
		int         sent;
		int         ticks;
		int         k;
		logic [1:0] ev;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 99) < 15) begin
				ev = 2'($urandom_range(0, 3));
				push_event(ev, $urandom);
				sent++;
			end else begin
				// start some gestures just short of the counter wrap
				if ($urandom_range(0, 9) == 0)
					ms_now = 32'hFFFF_FFFF - $urandom_range(0, 2000);
				ms_now += pick_gap();
				push_event(ptt_pkg::EV_PRESS, ms_now);
				sent++;
				ticks = $urandom_range(0, 6);
				for (k = 0; k < ticks; k++) begin
					ms_now += pick_gap();
					ev = ($urandom_range(0, 9) == 0) ? ptt_pkg::EV_PRESS : ptt_pkg::EV_TICK;
					push_event(ev, ms_now);
					sent++;
				end
				ms_now += pick_gap();
				case ($urandom_range(0, 9))
					7, 8: begin
						push_event(ptt_pkg::EV_CANCEL, ms_now);
						sent++;
					end
					9: ;  // leave the gesture open for the next press to meet
					default: begin
						push_event(ptt_pkg::EV_RELEASE, ms_now);
						sent++;
					end
				endcase
			end
		end
	endtask

	initial begin
		// Hold reset from time zero, then release it at a rising edge.
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset timing (arm 120, min speech 350, max talk 30000).
		// Idle events do nothing.
		push_event(ptt_pkg::EV_TICK, 32'h0000_0000);
		push_event(ptt_pkg::EV_RELEASE, 32'hFFFF_FFFF);
		push_event(ptt_pkg::EV_CANCEL, 32'h0000_0010);
		// Arm, ignore a second press, start exactly at the arm time, ignore a
		// press while talking, then release one millisecond short.
		push_event(ptt_pkg::EV_PRESS, 32'd1000);
		push_event(ptt_pkg::EV_PRESS, 32'd1010);
		push_event(ptt_pkg::EV_TICK, 32'd1119);
		push_event(ptt_pkg::EV_TICK, 32'd1120);
		push_event(ptt_pkg::EV_PRESS, 32'd1200);
		push_event(ptt_pkg::EV_RELEASE, 32'd1469);
		// Press clears the reason; release while arming drops back silently.
		push_event(ptt_pkg::EV_PRESS, 32'd2000);
		push_event(ptt_pkg::EV_RELEASE, 32'd2050);
		// Release at exactly the minimum speech time sends.
		push_event(ptt_pkg::EV_PRESS, 32'd3000);
		push_event(ptt_pkg::EV_TICK, 32'd3120);
		push_event(ptt_pkg::EV_RELEASE, 32'd3470);
		// Talk one millisecond under, then exactly at, the limit.
		push_event(ptt_pkg::EV_PRESS, 32'd4000);
		push_event(ptt_pkg::EV_TICK, 32'd4200);
		push_event(ptt_pkg::EV_TICK, 32'd34199);
		push_event(ptt_pkg::EV_TICK, 32'd34200);
		// Cancel while arming keeps the reason; cancel while talking clears it.
		push_event(ptt_pkg::EV_PRESS, 32'd40000);
		push_event(ptt_pkg::EV_CANCEL, 32'd40050);
		push_event(ptt_pkg::EV_PRESS, 32'hFFFF_FFF0);
		push_event(ptt_pkg::EV_TICK, 32'h0000_0068);
		push_event(ptt_pkg::EV_TICK, 32'h0000_0100);
		push_event(ptt_pkg::EV_CANCEL, 32'h0000_0200);
		push_event(ptt_pkg::EV_RELEASE, 32'h0000_0300);

		// Random part at reset timing.
		run_gestures(170);

		// Zero everywhere: start at once, send anything, no length limit.
		program_timing(24'h00_0000, 24'h00_0000, 24'h00_0000);
		run_gestures(170);

		// All ones: upper data bits of the 16-bit registers must be dropped.
		// Drop idling on both sides for this whole stretch.
		program_timing(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
		calm = 1'b1;
		run_gestures(170);
		calm = 1'b0;

		// Smallest nonzero thresholds.
		program_timing(24'h00_0001, 24'h00_0001, 24'h00_0001);
		run_gestures(85);
		// Pause the sender until every result is back, then resume.
		in_valid <= 1'b0;
		wait_drain();
		run_gestures(85);

		// Back to the reset values, then a few random settings.
		program_timing({8'd0, ptt_pkg::ARM_TIME_RST}, {8'd0, ptt_pkg::MIN_SPEECH_RST},
			ptt_pkg::MAX_TALK_RST);
		run_gestures(170);
		repeat (3) begin
			program_timing({8'($urandom), 16'($urandom_range(0, 600))},
				{8'($urandom), 16'($urandom_range(0, 2000))},
				($urandom_range(0, 3) == 0) ? 24'd0 : 24'($urandom_range(1, 50000)));
			run_gestures(170);
		end

		in_valid <= 1'b0;
		wait_drain();

		$display("Covered %0d events and %0d results over %0d timing settings:",
			sb.n_events, sb.n_results, n_settings);
		$display("  %0d talk starts, %0d sends, %0d discards.",
			sb.n_starts, sb.n_sends, sb.n_discards);
		if (sb.errors == 0)
			$display("push_to_talk_gesture_fsm_unit test passed");
		else
			$display("push_to_talk_gesture_fsm_unit test failed");
		$finish;
	end

	// Watchdog: end a run that hangs on a handshake.
	initial begin
		#400000;
		$display("%0t: timeout with %0d results outstanding", $time, sb.pending());
		$display("push_to_talk_gesture_fsm_unit test failed");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/ptt_pkg.sv
rtl/core/ptt_cfg_regs.sv
rtl/core/ptt_step.sv
rtl/core/push_to_talk_gesture_fsm_unit.sv
verif/push_to_talk_gesture_fsm_unit_tb.sv
